### src/phase_accumulator_oscillator_unit_macros.svh
// assertion helpers shared by the oscillator modules
`ifndef PHASE_ACCUMULATOR_OSCILLATOR_UNIT_MACROS_SVH
`define PHASE_ACCUMULATOR_OSCILLATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PAOU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PAOU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PAOU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PAOU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/paou_pkg.sv
`timescale 1ns / 1ps
package paou_pkg;

	localparam int PHASE_BITS_DEF  = 32;
	localparam int SINE_DEPTH_DEF  = 1024;
	localparam int SAMPLE_FRAC_DEF = 14;

	localparam int FREQ_W        = 24;
	localparam int PPH_W         = 28;
	localparam int SAMPLE_W      = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int PROD_W        = FREQ_W + PPH_W;
	// frequency * phase_per_hz is scaled for a 48-bit phase
	localparam int STEP_REF_BITS = 48;
	localparam int FIFO_DEPTH    = 2;

	localparam logic [PPH_W-1:0] PPH_RESET = 28'd24931095;

	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_PER_HZ = 2'd1;

	typedef enum logic [1:0] {
		WAVE_SINE,
		WAVE_SQUARE,
		WAVE_TRIANGLE,
		WAVE_SAW
	} wave_t;

	// pi/2 in unsigned Q30 and the Taylor divisors (2n)(2n+1)
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam int TAYLOR_TERMS = 12;
	localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	// front-to-back queue entry: waveform, phase, |phase - half|, saw sign
	function automatic int mq_width(input int pb);
		return 2 * pb + 3;
	endfunction

endpackage

### src/paou_fifo.sv
`timescale 1ns / 1ps
module paou_fifo import paou_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/paou_sine_rom.sv
`timescale 1ns / 1ps
module paou_sine_rom import paou_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_DEF
) (
	input  logic                                  clk,
	input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr,
	output logic [SAMPLE_FRAC_BITS:0]             data
);

	localparam int D = SINE_TABLE_DEPTH;
	localparam int F = SAMPLE_FRAC_BITS;
	localparam logic [63:0] DEPTH64 = 64'(SINE_TABLE_DEPTH);
	localparam logic [63:0] ONE64   = 64'd1 << F;

	logic [F:0] rom_w [0:D];
	logic [F:0] data_q;

	// quarter-wave entry, Taylor series in unsigned Q30, rounded to the sample scale
	function automatic logic [F:0] sine_entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		x    = (PI_HALF_Q30 * 64'(k)) / DEPTH64;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		e = ((sum << F) + (64'd1 << 29)) >> 30;
		if (e > ONE64) begin
			e = ONE64;
		end
		return e[F:0];
	endfunction

	for (genvar k = 0; k <= D; k++) begin : g_rom
		assign rom_w[k] = sine_entry(k);
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

	assign data = data_q;

endmodule

### src/paou_front.sv
`timescale 1ns / 1ps
`include "phase_accumulator_oscillator_unit_macros.svh"
module paou_front import paou_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [FREQ_W-1:0]                  frequency,
	input  logic [PPH_W-1:0]                   phase_per_hz,
	input  wave_t                              waveform,
	output logic                               mq_push,
	output logic [mq_width(PHASE_BITS)-1:0]    mq_data,
	input  logic                               mq_full
);

	localparam int PB         = PHASE_BITS;
	localparam int STEP_SHIFT = STEP_REF_BITS - PB;
	localparam logic [PB-1:0] HALF = {1'b1, {(PB-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_PUSH
	} state_t;

	state_t              st_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PB-1:0]       phase_q;
	logic [PB-1:0]       step;
	logic                saw_neg;
	logic [PB-1:0]       half_dist;

	assign full = (st_q != ST_IDLE);
	assign step = PB'(prod_q >> STEP_SHIFT);

	// distance from mid-cycle, shared by saw and triangle in the back end
	assign saw_neg   = (phase_q > HALF);
	assign half_dist = saw_neg ? (phase_q - HALF) : (HALF - phase_q);

	assign mq_push = (st_q == ST_PUSH) && !mq_full;
	assign mq_data = {waveform, phase_q, half_dist, saw_neg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			freq_q  <= '0;
			prod_q  <= '0;
			phase_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (push) begin
						freq_q <= frequency;
						st_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= PROD_W'(freq_q) * PROD_W'(phase_per_hz);
					st_q   <= ST_ADD;
				end
				ST_ADD: begin
					// wraps modulo one cycle
					phase_q <= phase_q + step;
					st_q    <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!mq_full) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PAOU_ASSERT_NEXT(a_accept_starts_mul, clk, arst_n, push && !full, st_q == ST_MUL, "accepted transaction did not start the multiply")
	`PAOU_ASSERT_NEXT(a_phase_only_in_add, clk, arst_n, st_q != ST_ADD, phase_q == $past(phase_q), "phase moved outside the accumulate step")
	`PAOU_ASSERT_NEXT(a_handoff_frees_input, clk, arst_n, mq_push, !full, "input not freed after hand-off to the queue")

endmodule

### src/paou_back.sv
`timescale 1ns / 1ps
`include "phase_accumulator_oscillator_unit_macros.svh"
module paou_back import paou_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            mq_empty,
	output logic                            mq_pop,
	input  logic [mq_width(PHASE_BITS)-1:0] mq_data,
	input  logic                            out_full,
	output logic                            out_push,
	output logic [SAMPLE_W-1:0]             out_data
);

	localparam int PB      = PHASE_BITS;
	localparam int D       = SINE_TABLE_DEPTH;
	localparam int F       = SAMPLE_FRAC_BITS;
	localparam int QW      = mq_width(PB);
	localparam int FOUR_D  = 4 * D;
	localparam int IDX_W   = $clog2(FOUR_D);
	localparam int IPROD_W = PB + $clog2(FOUR_D + 1);
	localparam int AW      = $clog2(D + 1);
	localparam int SH_DN   = (PB >= F) ? PB - F : 0;
	localparam int SH_UP   = (PB >= F) ? 0 : F - PB;
	localparam int RND_SH  = (PB > F) ? PB - F - 1 : 0;
	localparam int SAW_W   = PB + SH_UP + 1;
	localparam int TRI_W   = PB + SH_UP + 5;
	localparam int YW      = F + 3;
	localparam int MW      = F + 2;
	localparam int RW      = (F + 3 > SAMPLE_W) ? F + 3 : SAMPLE_W;

	localparam logic [PB:0]        HALF_E  = {2'b01, {(PB-1){1'b0}}};
	localparam logic [SAW_W-1:0]   SAW_RND = (PB > F) ? SAW_W'(64'd1 << RND_SH) : '0;
	localparam logic [TRI_W-1:0]   TRI_RND = TRI_W'(64'd5 << SH_DN);
	localparam logic [YW-1:0]      RECIP   = YW'((64'd1 << YW) / 64'd10);
	localparam logic [YW-1:0]      TEN     = YW'(10);
	localparam logic [IDX_W-1:0]   D_I     = IDX_W'(D);
	localparam logic [IDX_W-1:0]   TWO_D_I = IDX_W'(2 * D);
	localparam logic [MW-1:0]      ONE_M   = MW'(1) << F;

	typedef enum logic [1:0] {
		B_IDLE,
		B_S1,
		B_S2,
		B_S3
	} state_t;

	state_t           st_q;

	// queue entry fields
	wave_t            mq_wave;
	logic [PB-1:0]    mq_phase;
	logic [PB-1:0]    mq_half_dist;
	logic             mq_saw_neg;

	logic [IPROD_W-1:0] iprod;
	logic [IDX_W-1:0]   idx_calc;
	logic [PB:0]        twice_dist;
	logic               tri_neg_calc;
	logic [PB:0]        tri_m_calc;
	logic [SAW_W-1:0]   saw_sum;

	wave_t            wave_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PB-1:0]    tri_m_s1;
	logic             tri_neg_s1;
	logic [MW-1:0]    saw_mag_s1;
	logic             saw_neg_s1;
	logic             sq_neg_s1;

	logic             upper;
	logic [IDX_W-1:0] idx_half;
	logic             odd_quad;
	logic [IDX_W-1:0] offset;
	logic [AW-1:0]    addr_calc;
	logic [TRI_W-1:0] tri_m9;
	logic [TRI_W-1:0] tri_sum;

	logic [AW-1:0]    addr_s2;
	logic             upper_s2;
	logic [YW-1:0]    y_s2;

	logic [2*YW-1:0]  recip_prod;
	logic [YW-1:0]    q0_s3;

	logic [F:0]       rom_data;
	logic [YW-1:0]    rem;
	logic [YW-1:0]    tri_mag;
	logic [F+1:0]     sine_v;
	logic [MW-1:0]    mag;
	logic             neg;
	logic [RW-1:0]    res;

	assign mq_wave      = wave_t'(mq_data[QW-1 -: 2]);
	assign mq_phase     = mq_data[2*PB:PB+1];
	assign mq_half_dist = mq_data[PB:1];
	assign mq_saw_neg   = mq_data[0];

	assign mq_pop   = (st_q == B_IDLE) && !mq_empty;
	assign out_push = (st_q == B_S3) && !out_full;

	// pop cycle: table index, triangle fold, saw rounding
	always_comb begin
		iprod        = IPROD_W'(mq_phase) * IPROD_W'(FOUR_D);
		idx_calc     = IDX_W'(iprod >> PB);
		twice_dist   = {mq_half_dist, 1'b0};
		tri_neg_calc = (twice_dist < HALF_E);
		tri_m_calc   = tri_neg_calc ? (HALF_E - twice_dist) : (twice_dist - HALF_E);
		saw_sum      = (SAW_W'(mq_half_dist) << SH_UP) + SAW_RND;
	end

	// first step: quadrant and table address, triangle numerator
	always_comb begin
		upper     = (idx_s1 >= TWO_D_I);
		idx_half  = upper ? (idx_s1 - TWO_D_I) : idx_s1;
		odd_quad  = (idx_half >= D_I);
		offset    = odd_quad ? (idx_half - D_I) : idx_half;
		addr_calc = odd_quad ? AW'(D_I - offset) : AW'(offset);
		tri_m9    = (TRI_W'(tri_m_s1) << 3) + TRI_W'(tri_m_s1);
		tri_sum   = (tri_m9 << SH_UP) + TRI_RND;
	end

	// divide by ten: reciprocal estimate is low by at most one
	assign recip_prod = (2*YW)'(y_s2) * (2*YW)'(RECIP);

	always_comb begin
		rem     = y_s2 - ((q0_s3 << 3) + (q0_s3 << 1));
		tri_mag = (rem >= TEN) ? (q0_s3 + YW'(1)) : q0_s3;
		sine_v  = upper_s2 ? ((F+2)'(ONE_M) - (F+2)'(rom_data))
			: ((F+2)'(ONE_M) + (F+2)'(rom_data));
		case (wave_s1)
			WAVE_SINE: begin
				mag = MW'(sine_v >> 1);
				neg = 1'b0;
			end
			WAVE_SQUARE: begin
				mag = ONE_M;
				neg = sq_neg_s1;
			end
			WAVE_TRIANGLE: begin
				mag = MW'(tri_mag);
				neg = tri_neg_s1;
			end
			WAVE_SAW: begin
				mag = saw_mag_s1;
				neg = saw_neg_s1;
			end
			default: begin
				mag = '0;
				neg = 1'b0;
			end
		endcase
		res = neg ? (RW'(0) - RW'(mag)) : RW'(mag);
	end

	assign out_data = res[SAMPLE_W-1:0];

	paou_sine_rom #(
		.SINE_TABLE_DEPTH (D),
		.SAMPLE_FRAC_BITS (F)
	) u_rom (
		.clk  (clk),
		.addr (addr_s2),
		.data (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			wave_s1    <= WAVE_SINE;
			idx_s1     <= '0;
			tri_m_s1   <= '0;
			tri_neg_s1 <= 1'b0;
			saw_mag_s1 <= '0;
			saw_neg_s1 <= 1'b0;
			sq_neg_s1  <= 1'b0;
			addr_s2    <= '0;
			upper_s2   <= 1'b0;
			y_s2       <= '0;
			q0_s3      <= '0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (!mq_empty) begin
						wave_s1    <= mq_wave;
						idx_s1     <= idx_calc;
						tri_m_s1   <= tri_m_calc[PB-1:0];
						tri_neg_s1 <= tri_neg_calc;
						saw_mag_s1 <= MW'(saw_sum >> SH_DN);
						saw_neg_s1 <= mq_saw_neg;
						sq_neg_s1  <= !mq_phase[PB-1];
						st_q       <= B_S1;
					end
				end
				B_S1: begin
					addr_s2  <= addr_calc;
					upper_s2 <= upper;
					y_s2     <= YW'(tri_sum >> SH_DN);
					st_q     <= B_S2;
				end
				B_S2: begin
					q0_s3 <= YW'(recip_prod >> YW);
					st_q  <= B_S3;
				end
				B_S3: begin
					if (!out_full) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	`PAOU_ASSERT_NEXT(a_pop_starts_work, clk, arst_n, mq_pop, st_q == B_S1, "queue pop did not start the back end")
	`PAOU_ASSERT_NEXT(a_result_returns_idle, clk, arst_n, out_push, st_q == B_IDLE, "back end not idle after writing a result")
	`PAOU_ASSERT_NEXT(a_stall_holds_result, clk, arst_n, (st_q == B_S3) && out_full, (st_q == B_S3) && $stable(q0_s3) && $stable(addr_s2), "stalled result changed")

endmodule

### src/phase_accumulator_oscillator_unit.sv
`timescale 1ns / 1ps
// Multi-waveform oscillator. Each transaction pushed in carries a frequency in Hz
// (unsigned, 8 fractional bits); the block advances its phase accumulator by
// frequency * phase_per_hz, wrapping modulo one cycle, and queues one signed
// sample with SAMPLE_FRAC_BITS fractional bits (sine, square, triangle or saw,
// chosen by the waveform register). The front end accepts a transaction, does the
// frequency multiply and the accumulator add, and hands the phase over a 2-entry
// queue; it takes no new transaction until that hand-off, which waits while the
// queue is full. Once idle, the back end pops an entry with the sine table index
// multiply, folds the quadrant into a table address and forms the triangle
// numerator, does the registered table read beside the divide-by-ten reciprocal
// multiply for the triangle, then writes the 2-entry result queue, waiting while full.
// The configuration channel is always ready and should only be written while
// no transaction is in flight. There is no clearing pass after reset.
module phase_accumulator_oscillator_unit import paou_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [FREQ_W-1:0]          frequency,
	input  logic                       pop,
	output logic                       empty,
	output logic signed [SAMPLE_W-1:0] sample,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [PPH_W-1:0]           cfg_data
);

	localparam int QW = mq_width(PHASE_BITS);

	wave_t              waveform_q;
	logic [PPH_W-1:0]   phase_per_hz_q;

	logic               mq_push;
	logic               mq_pop;
	logic               mq_full;
	logic               mq_empty;
	logic [QW-1:0]      mq_wdata;
	logic [QW-1:0]      mq_rdata;

	logic               out_push;
	logic               out_full;
	logic [SAMPLE_W-1:0] out_wdata;
	logic [SAMPLE_W-1:0] out_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q     <= WAVE_SINE;
			phase_per_hz_q <= PPH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WAVEFORM: begin
					waveform_q <= wave_t'(cfg_data[1:0]);
				end
				REG_PHASE_PER_HZ: begin
					phase_per_hz_q <= cfg_data;
				end
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	paou_front #(
		.PHASE_BITS (PHASE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.frequency    (frequency),
		.phase_per_hz (phase_per_hz_q),
		.waveform     (waveform_q),
		.mq_push      (mq_push),
		.mq_data      (mq_wdata),
		.mq_full      (mq_full)
	);

	paou_fifo #(
		.W     (QW),
		.DEPTH (FIFO_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.pop    (mq_pop),
		.rdata  (mq_rdata),
		.empty  (mq_empty)
	);

	paou_back #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_empty (mq_empty),
		.mq_pop   (mq_pop),
		.mq_data  (mq_rdata),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	paou_fifo #(
		.W     (SAMPLE_W),
		.DEPTH (FIFO_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign sample = $signed(out_rdata);

endmodule

### dv/phase_accumulator_oscillator_unit_checker.sv
`timescale 1ns / 1ps
module phase_accumulator_oscillator_unit_checker import paou_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [FREQ_W-1:0]          frequency,
	input  logic                       pop,
	input  logic                       empty,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [PPH_W-1:0]           cfg_data,
	output int                         errors,
	output int                         pending
);

	localparam int PB    = PHASE_BITS_DEF;
	localparam int DEPTH = SINE_DEPTH_DEF;
	localparam int FRAC  = SAMPLE_FRAC_DEF;
	localparam logic [63:0] ONE  = 64'd1 << FRAC;
	localparam logic [63:0] HALF = 64'd1 << (PB - 1);
	localparam logic [63:0] TURN = 64'd1 << PB;

	logic [63:0]                quarter_sine [0:DEPTH];
	logic [PB-1:0]              osc_phase;
	wave_t                      osc_wave;
	logic [PPH_W-1:0]           osc_step;
	logic signed [SAMPLE_W-1:0] due_samples [$];

	// sine in unsigned Q30 by a truncated Taylor series
	function automatic logic [63:0] taylor_sine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// round half up of m * mul / div, brought from phase scale to sample scale
	function automatic logic [63:0] rounded_mag(input logic [63:0] m, input logic [63:0] mul,
		input logic [63:0] div);
		logic [63:0] den;
		den = div << (PB - FRAC);
		return (m * mul + den / 2) / den;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] apply_sign(input logic neg,
		input logic [63:0] mag);
		logic [63:0] r;
		r = neg ? (64'd0 - mag) : mag;
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] wave_sample(input logic [PB-1:0] ph,
		input wave_t w);
		logic [63:0] idx;
		logic [63:0] quad;
		logic [63:0] off;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] twice;
		logic [63:0] fold;
		logic [63:0] m;
		logic        neg;
		case (w)
			WAVE_SINE: begin
				idx = (64'(ph) * 4 * DEPTH) >> PB;
				quad = (idx / DEPTH) & 64'd3;
				off = idx % DEPTH;
				s = quad[0] ? quarter_sine[DEPTH - off] : quarter_sine[off];
				v = quad[1] ? (ONE - s) : (ONE + s);
				return v[SAMPLE_W:1];
			end
			WAVE_SQUARE: return apply_sign(64'(ph) < HALF, ONE);
			WAVE_TRIANGLE: begin
				twice = 64'(ph) << 1;
				fold = (twice >= TURN) ? (twice - TURN) : (TURN - twice);
				neg = fold < HALF;
				m = neg ? (HALF - fold) : (fold - HALF);
				return apply_sign(neg, rounded_mag(m, 64'd9, 64'd10));
			end
			default: begin
				neg = 64'(ph) > HALF;
				m = neg ? (64'(ph) - HALF) : (HALF - 64'(ph));
				return apply_sign(neg, rounded_mag(m, 64'd1, 64'd1));
			end
		endcase
	endfunction

	initial begin
		logic [63:0] e;
		for (int k = 0; k <= DEPTH; k++) begin
			e = ((taylor_sine((PI_HALF_Q30 * 64'(k)) / DEPTH) << FRAC) + (64'd1 << 29)) >> 30;
			quarter_sine[k] = (e > ONE) ? ONE : e;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [SAMPLE_W-1:0] want;
		logic [63:0]                advance;
		if (!arst_n) begin
			osc_phase = '0;
			osc_wave = WAVE_SINE;
			osc_step = PPH_RESET;
			due_samples.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// indexes past the register list are dropped
				if (cfg_index == REG_WAVEFORM) begin
					osc_wave = wave_t'(cfg_data[1:0]);
				end else if (cfg_index == REG_PHASE_PER_HZ) begin
					osc_step = cfg_data;
				end
			end
			if (pop && !empty) begin
				if (due_samples.size() == 0) begin
					errors++;
					$display("%0t: unexpected sample, expected none, actual %0d", $time, sample);
				end else begin
					want = due_samples.pop_front();
					if (sample !== want) begin
						errors++;
						$display("%0t: sample mismatch, expected %0d, actual %0d",
							$time, want, sample);
					end
				end
			end
			if (push && !full) begin
				advance = (64'(frequency) * 64'(osc_step)) >> (STEP_REF_BITS - PB);
				osc_phase = osc_phase + advance[PB-1:0];
				due_samples.insert(due_samples.size(), wave_sample(osc_phase, osc_wave));
			end
			pending = due_samples.size();
		end
	end

endmodule

### dv/phase_accumulator_oscillator_unit_tb.sv
`timescale 1ns / 1ps
module phase_accumulator_oscillator_unit_tb import paou_pkg::*;;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 95;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [PPH_W-1:0] STEP_ALIGNED = 28'h8000000;
	localparam logic [PPH_W-1:0] STEP_MAX     = 28'hFFFFFFF;
	localparam logic [FREQ_W-1:0] FREQ_MAX     = 24'hFFFFFF;
	localparam logic [FREQ_W-1:0] FREQ_QUARTER = 24'h080000;
	localparam logic [FREQ_W-1:0] FREQ_HALF    = 24'h100000;

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [FREQ_W-1:0]          frequency;
	logic                       pop;
	logic                       empty;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [PPH_W-1:0]           cfg_data;

	int fail_count;
	int samples_due;
	int cycle_count;
	int tx_idle_pct;
	int rx_stall_pct;
	int holds_asked;
	int holds_served;

	phase_accumulator_oscillator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.frequency (frequency),
		.pop       (pop),
		.empty     (empty),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	phase_accumulator_oscillator_unit_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.frequency (frequency),
		.pop       (pop),
		.empty     (empty),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.pending   (samples_due)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off whenever one is asked for
	initial begin
		pop = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_frequency(input logic [FREQ_W-1:0] f);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		frequency <= f;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (samples_due != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PPH_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// upper data bits are noise on the waveform write
	task automatic reconfigure(input wave_t w, input logic [PPH_W-1:0] step);
		wait_drained();
		write_reg(REG_WAVEFORM, (PPH_W'($urandom()) & ~PPH_W'(3)) | PPH_W'(w));
		write_reg(REG_PHASE_PER_HZ, step);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [FREQ_W-1:0] next_frequency();
		case ($urandom_range(0, 3))
			0: return FREQ_W'($urandom_range(0, 20000 * 256));
			1: return FREQ_W'($urandom_range(0, 255));
			default: return FREQ_W'($urandom());
		endcase
	endfunction

	initial begin
		logic [PPH_W-1:0] step;
		arst_n = 1'b0;
		push = 1'b0;
		frequency = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WAVEFORM;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		holds_asked = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero phase under the reset settings
		send_frequency('0);
		// with this step the quarter and half frequencies keep the phase on exact quarter points
		reconfigure(WAVE_SINE, STEP_ALIGNED);
		repeat (4) send_frequency(FREQ_QUARTER);
		reconfigure(WAVE_SQUARE, STEP_ALIGNED);
		repeat (2) send_frequency(FREQ_HALF);
		reconfigure(WAVE_TRIANGLE, STEP_ALIGNED);
		repeat (3) send_frequency(FREQ_QUARTER);
		reconfigure(WAVE_SAW, STEP_ALIGNED);
		send_frequency(FREQ_QUARTER);
		send_frequency(FREQ_HALF);
		send_frequency(24'd1);
		// steps beyond a whole cycle
		reconfigure(WAVE_SQUARE, STEP_MAX);
		send_frequency(FREQ_MAX);
		send_frequency(24'h800000);
		// stuck phase, and writes to indexes with no register behind them
		wait_drained();
		write_reg(REG_SPARE_A, PPH_W'($urandom()));
		write_reg(REG_SPARE_B, PPH_W'($urandom()));
		reconfigure(WAVE_TRIANGLE, '0);
		send_frequency(FREQ_MAX);
		send_frequency(24'h123456);
		reconfigure(WAVE_SINE, 28'd1);
		send_frequency(FREQ_MAX);
		send_frequency(24'd1);
		reconfigure(WAVE_SAW, PPH_RESET);
		send_frequency(24'd440 * 24'd256);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: step = STEP_MAX;
				1: step = 28'd1;
				2: step = PPH_RESET;
				default: step = PPH_W'($urandom_range(1, STEP_MAX));
			endcase
			reconfigure(wave_t'(ph % 4), step);
			case (ph / 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 50;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 50;
				end
				default: begin
					tx_idle_pct = 15;
					rx_stall_pct = 15;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// fill the block against a stalled result side
				if ((ph == 2 || ph == 13) && n == 20) holds_asked++;
				if (ph == 6 && n == 40) wait_drained();
				send_frequency(next_frequency());
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
